// File: sv/pfi_pkg.sv
// Shared types, constants and fixed-point helpers for the particle force integrator.
package pfi_pkg;

    // Item kinds carried on s_tuser
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_CONST   = 3'd1;
    localparam logic [2:0] KIND_REPEL   = 3'd2;
    localparam logic [2:0] KIND_ATTRACT = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    // Configuration register indexes
    localparam logic [7:0] REG_DAMP   = 8'd0;
    localparam logic [7:0] REG_PINNED = 8'd1;
    localparam logic [7:0] REG_WALL_W = 8'd2;
    localparam logic [7:0] REG_WALL_H = 8'd3;

    // Register reset values
    localparam logic [16:0] DAMP_RST   = 17'd16384;
    localparam logic [12:0] WALL_W_RST = 13'd1024;
    localparam logic [12:0] WALL_H_RST = 13'd768;

    // 0.3 in Q0.16
    localparam logic [31:0] BOUNCE_GAIN = 32'd19661;
    localparam logic [16:0] Q_ONE       = 17'd65536;

    // Divider shape: 49-bit dividend, 33-bit divisor, quotient known below 2^17
    localparam int DVD_W = 49;
    localparam int DVS_W = 33;
    localparam int QUO_W = 17;

    typedef logic signed [31:0] q16_t;

    // Clamp a widened sum to the signed 32-bit range
    function automatic q16_t sat32(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Magnitude of a signed word; -2^31 gives 2^31
    function automatic logic [31:0] vmag(input q16_t v);
        logic signed [32:0] e;
        e = {v[31], v};
        return v[31] ? 32'(-e) : 32'(e);
    endfunction

    // Sign extension to the sum width
    function automatic logic signed [34:0] ext35(input q16_t v);
        return {{3{v[31]}}, v};
    endfunction

endpackage

// File: sv/pfi_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module pfi_mul import pfi_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    // product is registered and lands in the cycle after the operands
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

// File: sv/pfi_sqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
module pfi_sqrt import pfi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem2;
    logic [34:0] trial;
    logic        ge;

    // one digit step
    always_comb
    begin
        rem2  = {rem_reg[32:0], rad_reg[63:62]};
        trial = {1'b0, root_reg, 2'b01};
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[61:0], 2'b00};
                rem_reg  <= ge ? 34'(rem2 - trial) : rem2[33:0];
                root_reg <= {root_reg[30:0], ge};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: sv/pfi_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient below 2^QUO_W.
module pfi_div import pfi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DVS_W-1:0]   divisor,
    output logic               done,
    output logic [QUO_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem2;
    logic             ge;

    // shift in the next dividend bit and compare
    always_comb
    begin
        rem2 = {rem_reg, quo_reg[QUO_W-1]};
        ge   = (rem2 >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
                rem_reg  <= DVS_W'(dividend[DVD_W-1:QUO_W]);
                quo_reg  <= dividend[QUO_W-1:0];
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DVS_W'(rem2 - {1'b0, dvs_reg}) : rem2[DVS_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/particle_force_integrator.sv
// Top level: particle state, sequencer and the shared multiply, root and divide units.
//
//  channel | signals                               | direction | carries
//  s_*     | s_tvalid s_tready s_tdata s_tuser     | in        | one input item
//  m_*     | m_tvalid m_tready m_tdata m_tuser     | out       | state after a tick
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data| in        | register write
//
// Load, constant force and unused kinds are taken in ST_IDLE and leave s_tready high.
// A tick holds s_tready low while it runs on the multiplier, used once per axis for
// damping and again for the bounce; a pinned particle skips the velocity and position updates.
// Repel and attract end early when the particle sits on the point or is outside the reach.
// 32 square-root steps run on the root unit, and four 17-step divisions (three with a zero
// reach) share one divider. s_tready is low while an item is in work.
// A tick waits in its last step while a prior result is still held on m_*.
// Reset clears position, velocity and force and loads the register defaults.
module particle_force_integrator import pfi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, reach[30:0], strength, one pad bit
    input  logic [255:0] s_tdata,
    // kind
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    output logic [191:0] m_tdata,
    // hit_wall
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_PF_DIFF, ST_PF_SQ, ST_PF_SQACC, ST_PF_SQRT, ST_PF_LEN, ST_PF_PCT,
        ST_PF_SMUL, ST_PF_SMUL_W, ST_PF_NDIV, ST_PF_NWAIT, ST_PF_FLO, ST_PF_FLO_W,
        ST_PF_FHI_W, ST_TK_DMUL, ST_TK_DACC, ST_TK_INTV, ST_TK_INTP, ST_TK_WALL,
        ST_TK_BMUL, ST_TK_BACC, ST_TK_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [16:0] damp_reg;
    logic        pinned_reg;
    logic [12:0] wall_w_reg;
    logic [12:0] wall_h_reg;

    // particle state
    q16_t pos_reg [3];
    q16_t vel_reg [3];
    q16_t frc_reg [3];

    // latched item
    q16_t        pt_reg [3];
    logic [30:0] reach_reg;
    q16_t        str_reg;
    logic        attract_reg;

    // point force working values
    logic [32:0] m_reg [3];
    logic        dneg_reg [3];
    logic        big_reg;
    logic [63:0] sum_reg;
    logic [32:0] len_reg;
    logic [16:0] pct_reg;
    logic [48:0] p1_reg;
    logic [16:0] n_reg;
    logic [16:0] lo_reg;
    logic [1:0]  idx_reg;
    logic        hit_reg;

    // unit controls
    logic              sq_start_reg;
    logic              dv_start_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;

    // output register
    logic         m_valid_reg;
    logic [191:0] m_data_reg;
    logic         m_hit_reg;

    // shared unit connections
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        sq_done;
    logic [31:0] sq_root;
    logic        dv_done;
    logic [QUO_W-1:0] dv_q;

    // combinational helpers
    logic        s_acc;
    logic [32:0] d_mag [3];
    logic        d_neg [3];
    logic        d_big;
    logic [31:0] sq_t;
    logic [31:0] v_mag;
    logic        v_neg;
    logic [32:0] dmp_p;
    logic signed [34:0] dmp_sum;
    logic [31:0] f_mag;
    logic        f_neg;
    logic signed [34:0] f_sum;
    logic [28:0] hx;
    logic [28:0] hy;
    logic        x_hi, x_lo, y_hi, y_lo;

    pfi_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pfi_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start_reg),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    pfi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_hit_reg;

    // offsets from the point, per axis
    always_comb
    begin
        d_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [32:0] d;
            d        = {pos_reg[i][31], pos_reg[i]} - {pt_reg[i][31], pt_reg[i]};
            d_neg[i] = d[32];
            d_mag[i] = d[32] ? 33'(-d) : 33'(d);
            d_big    = d_big | d_mag[i][32] | d_mag[i][31];
        end
    end

    // per-axis arithmetic around the shared multiplier
    always_comb
    begin
        sq_t    = big_reg ? m_reg[idx_reg][32:1] : m_reg[idx_reg][31:0];
        v_mag   = vmag(vel_reg[idx_reg]);
        v_neg   = vel_reg[idx_reg][31];
        dmp_p   = mul_p[48:16];
        dmp_sum = v_neg ? ext35(frc_reg[idx_reg]) + $signed({2'b00, dmp_p})
                        : ext35(frc_reg[idx_reg]) - $signed({2'b00, dmp_p});
        f_mag   = mul_p[31:0] + {15'd0, lo_reg};
        f_neg   = dneg_reg[idx_reg] ^ str_reg[31] ^ attract_reg;
        f_sum   = f_neg ? ext35(frc_reg[idx_reg]) - $signed({3'b000, f_mag})
                        : ext35(frc_reg[idx_reg]) + $signed({3'b000, f_mag});
    end

    // wall compares, signed so a negative position is only below the low wall
    always_comb
    begin
        hx   = {wall_w_reg, 16'd0};
        hy   = {wall_h_reg, 16'd0};
        x_hi = $signed(pos_reg[0]) > $signed({3'd0, hx});
        x_lo = pos_reg[0][31];
        y_hi = $signed(pos_reg[1]) > $signed({3'd0, hy});
        y_lo = pos_reg[1][31];
    end

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_PF_SQ:
            begin
                mul_a = sq_t;
                mul_b = sq_t;
            end
            ST_PF_SMUL:
            begin
                mul_a = {15'd0, pct_reg};
                mul_b = vmag(str_reg);
            end
            ST_PF_FLO:
            begin
                mul_a = p1_reg[31:0];
                mul_b = {15'd0, n_reg};
            end
            ST_PF_FLO_W:
            begin
                mul_a = {15'd0, p1_reg[48:32]};
                mul_b = {15'd0, n_reg};
            end
            ST_TK_DMUL:
            begin
                mul_a = v_mag;
                mul_b = {15'd0, damp_reg};
            end
            ST_TK_BMUL:
            begin
                mul_a = v_mag;
                mul_b = BOUNCE_GAIN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_reg   <= DAMP_RST;
            pinned_reg <= 1'b0;
            wall_w_reg <= WALL_W_RST;
            wall_h_reg <= WALL_H_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DAMP:   damp_reg   <= cfg_data;
                REG_PINNED: pinned_reg <= cfg_data[0];
                REG_WALL_W: wall_w_reg <= cfg_data[12:0];
                REG_WALL_H: wall_h_reg <= cfg_data[12:0];
                default:    ;
            endcase
        end
    end

    // sequencer, particle state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_hit_reg    <= 1'b0;
            hit_reg      <= 1'b0;
            big_reg      <= 1'b0;
            sum_reg      <= '0;
            len_reg      <= '0;
            pct_reg      <= '0;
            p1_reg       <= '0;
            n_reg        <= '0;
            lo_reg       <= '0;
            dvd_reg      <= '0;
            dvs_reg      <= '0;
            reach_reg    <= '0;
            str_reg      <= '0;
            attract_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                frc_reg[i]  <= '0;
                pt_reg[i]   <= '0;
                m_reg[i]    <= '0;
                dneg_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            // the publish step below sets the flag itself
            if (m_valid_reg && m_tready && state_reg != ST_TK_OUT)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        for (int i = 0; i < 3; i++)
                            pt_reg[i] <= s_tdata[32*i +: 32];
                        reach_reg   <= s_tdata[222:192];
                        str_reg     <= s_tdata[254:223];
                        attract_reg <= (s_tuser == KIND_ATTRACT);
                        idx_reg     <= '0;
                        case (s_tuser)
                            KIND_LOAD:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    pos_reg[i] <= s_tdata[32*i +: 32];
                                    vel_reg[i] <= s_tdata[96 + 32*i +: 32];
                                    frc_reg[i] <= '0;
                                end
                            end
                            KIND_CONST:
                            begin
                                for (int i = 0; i < 3; i++)
                                    frc_reg[i] <= sat32(ext35(frc_reg[i])
                                                  + ext35(s_tdata[32*i +: 32]));
                            end
                            KIND_REPEL, KIND_ATTRACT: state_reg <= ST_PF_DIFF;
                            KIND_TICK:                state_reg <= ST_TK_DMUL;
                            default:                  ;
                        endcase
                    end
                end

                // offsets and magnitudes
                ST_PF_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]    <= d_mag[i];
                        dneg_reg[i] <= d_neg[i];
                    end
                    big_reg   <= d_big;
                    sum_reg   <= '0;
                    state_reg <= ST_PF_SQ;
                end

                ST_PF_SQ: state_reg <= ST_PF_SQACC;

                ST_PF_SQACC:
                begin
                    sum_reg <= sum_reg + mul_p;
                    if (idx_reg == 2'd2)
                    begin
                        sq_start_reg <= 1'b1;
                        state_reg    <= ST_PF_SQRT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_PF_SQ;
                    end
                end

                ST_PF_SQRT:
                begin
                    if (sq_done)
                    begin
                        len_reg   <= big_reg ? {sq_root, 1'b0} : {1'b0, sq_root};
                        state_reg <= ST_PF_LEN;
                    end
                end

                // zero length and reach checks, falloff
                ST_PF_LEN:
                begin
                    if (len_reg == '0)
                        state_reg <= ST_IDLE;
                    else if (reach_reg == '0)
                    begin
                        pct_reg   <= Q_ONE;
                        state_reg <= ST_PF_SMUL;
                    end
                    else if (len_reg > {2'b00, reach_reg})
                        state_reg <= ST_IDLE;
                    else
                    begin
                        dvd_reg      <= {2'b00, 31'(reach_reg - len_reg[30:0]), 16'd0};
                        dvs_reg      <= {2'b00, reach_reg};
                        dv_start_reg <= 1'b1;
                        state_reg    <= ST_PF_PCT;
                    end
                end

                ST_PF_PCT:
                begin
                    if (dv_done)
                    begin
                        pct_reg   <= dv_q;
                        state_reg <= ST_PF_SMUL;
                    end
                end

                ST_PF_SMUL: state_reg <= ST_PF_SMUL_W;

                ST_PF_SMUL_W:
                begin
                    p1_reg    <= mul_p[48:0];
                    idx_reg   <= '0;
                    state_reg <= ST_PF_NDIV;
                end

                // normal component for this axis
                ST_PF_NDIV:
                begin
                    dvd_reg      <= {m_reg[idx_reg], 16'd0};
                    dvs_reg      <= len_reg;
                    dv_start_reg <= 1'b1;
                    state_reg    <= ST_PF_NWAIT;
                end

                ST_PF_NWAIT:
                begin
                    if (dv_done)
                    begin
                        n_reg     <= dv_q;
                        state_reg <= ST_PF_FLO;
                    end
                end

                ST_PF_FLO: state_reg <= ST_PF_FLO_W;

                ST_PF_FLO_W:
                begin
                    lo_reg    <= mul_p[48:32];
                    state_reg <= ST_PF_FHI_W;
                end

                ST_PF_FHI_W:
                begin
                    frc_reg[idx_reg] <= sat32(f_sum);
                    if (idx_reg == 2'd2)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_PF_NDIV;
                    end
                end

                // damping into the force
                ST_TK_DMUL: state_reg <= ST_TK_DACC;

                ST_TK_DACC:
                begin
                    frc_reg[idx_reg] <= sat32(dmp_sum);
                    if (idx_reg == 2'd2)
                        state_reg <= ST_TK_INTV;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_TK_DMUL;
                    end
                end

                ST_TK_INTV:
                begin
                    if (pinned_reg)
                        state_reg <= ST_TK_WALL;
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            vel_reg[i] <= sat32(ext35(vel_reg[i]) + ext35(frc_reg[i]));
                        state_reg <= ST_TK_INTP;
                    end
                end

                ST_TK_INTP:
                begin
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= sat32(ext35(pos_reg[i]) + ext35(vel_reg[i]));
                    state_reg <= ST_TK_WALL;
                end

                // clamp x and y, reverse velocity on contact
                ST_TK_WALL:
                begin
                    if (x_hi || x_lo)
                    begin
                        pos_reg[0] <= x_hi ? {3'd0, hx} : '0;
                        vel_reg[0] <= sat32(-ext35(vel_reg[0]));
                    end
                    if (y_hi || y_lo)
                    begin
                        pos_reg[1] <= y_hi ? {3'd0, hy} : '0;
                        vel_reg[1] <= sat32(-ext35(vel_reg[1]));
                    end
                    hit_reg   <= x_hi || x_lo || y_hi || y_lo;
                    idx_reg   <= '0;
                    state_reg <= (x_hi || x_lo || y_hi || y_lo) ? ST_TK_BMUL : ST_TK_OUT;
                end

                ST_TK_BMUL: state_reg <= ST_TK_BACC;

                ST_TK_BACC:
                begin
                    vel_reg[idx_reg] <= v_neg ? -$signed({1'b0, mul_p[46:16]})
                                              : $signed({1'b0, mul_p[46:16]});
                    if (idx_reg == 2'd2)
                        state_reg <= ST_TK_OUT;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_TK_BMUL;
                    end
                end

                // publish the state once the output register is free
                ST_TK_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {vel_reg[2], vel_reg[1], vel_reg[0],
                                        pos_reg[2], pos_reg[1], pos_reg[0]};
                        m_hit_reg   <= hit_reg;
                        for (int i = 0; i < 3; i++)
                            frc_reg[i] <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/pfi_check.sv
// Port-level checks for the particle force integrator, bound to the top level.
module pfi_check import pfi_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [255:0] s_tdata,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [7:0]   cfg_index,
    input logic [16:0]  cfg_data
);

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a tick keeps the block busy once it is taken
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_TICK |=> !s_tready)
        else $error("ready after tick accept");

    // point forces run on the shared units
    a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_REPEL || s_tuser == KIND_ATTRACT)
        |=> !s_tready ##1 !s_tready)
        else $error("point force finished too early");

    // after the wall clamp x and y are never negative
    a_walls: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31] && !m_tdata[63])
        else $error("position outside walls");

endmodule

bind particle_force_integrator pfi_check u_pfi_check (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the particle force integrator.
module testbench;
    import pfi_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 200;

    typedef struct {
        logic [2:0]  kind;
        int          px, py, pz;
        int          vx, vy, vz;
        logic [30:0] reach;
        int          strength;
    } item_t;

    typedef struct {
        int   op[6];
        logic hit;
    } state_t;

    // Shadow particle: tracks state and registers, queues the state each tick emits
    class state_tracker;
        longint          pos[3], vel[3], frc[3];
        longint unsigned damp, ww, wh;
        bit              pin;
        state_t          tick_states[$];
        int              errors;

        function new();
            damp = DAMP_RST; pin = 0; ww = WALL_W_RST; wh = WALL_H_RST;
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = 0; vel[i] = 0; frc[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [16:0] val);
            case (idx)
                REG_DAMP:   damp = val;
                REG_PINNED: pin = val[0];
                REG_WALL_W: ww = val[12:0];
                REG_WALL_H: wh = val[12:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned absval(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        // trunc(v * g / 2^16) on magnitudes
        function longint mul_q16(longint v, longint unsigned g);
            longint unsigned p;
            p = (absval(v) * g) >> 16;
            return v < 0 ? -longint'(p) : longint'(p);
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Repel or attract from a point with linear falloff
        function void point_push(item_t it, bit attract);
            longint          d[3];
            longint unsigned m[3], sum, len, pct, rch, smag, n, f, t;
            int              pt[3];
            bit              big, neg;
            pt[0] = it.px; pt[1] = it.py; pt[2] = it.pz;
            big = 0;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = pos[i] - longint'(pt[i]);
                m[i] = absval(d[i]);
                if (m[i] >= 64'h8000_0000)
                    big = 1;
            end
            for (int i = 0; i < 3; i++)
            begin
                t = big ? (m[i] >> 1) : m[i];
                sum += t * t;
            end
            len = root(sum);
            if (big)
                len <<= 1;
            if (len == 0)
                return;
            rch = it.reach;
            if (rch == 0)
                pct = 65536;
            else
            begin
                if (len > rch)
                    return;
                pct = ((rch - len) << 16) / rch;
            end
            smag = absval(longint'(it.strength));
            for (int i = 0; i < 3; i++)
            begin
                n = (m[i] << 16) / len;
                f = (n * smag * pct) >> 32;
                neg = (d[i] < 0) ^ (it.strength < 0) ^ attract;
                frc[i] = clip(frc[i] + (neg ? -longint'(f) : longint'(f)));
            end
        endfunction

        function bit bounce(int ax, longint hi);
            if (pos[ax] > hi)
                pos[ax] = hi;
            else if (pos[ax] < 0)
                pos[ax] = 0;
            else
                return 0;
            vel[ax] = clip(-vel[ax]);
            return 1;
        endfunction

        // Apply one accepted input item
        function void note_item(item_t it);
            int     a[3], b[3];
            bit     hit;
            state_t s;
            a[0] = it.px; a[1] = it.py; a[2] = it.pz;
            b[0] = it.vx; b[1] = it.vy; b[2] = it.vz;
            case (it.kind)
                KIND_LOAD:
                    for (int i = 0; i < 3; i++)
                    begin
                        pos[i] = a[i]; vel[i] = b[i]; frc[i] = 0;
                    end
                KIND_CONST:
                    for (int i = 0; i < 3; i++)
                        frc[i] = clip(frc[i] + longint'(a[i]));
                KIND_REPEL:   point_push(it, 0);
                KIND_ATTRACT: point_push(it, 1);
                KIND_TICK:
                begin
                    for (int i = 0; i < 3; i++)
                        frc[i] = clip(frc[i] - mul_q16(vel[i], damp));
                    if (!pin)
                        for (int i = 0; i < 3; i++)
                        begin
                            vel[i] = clip(vel[i] + frc[i]);
                            pos[i] = clip(pos[i] + vel[i]);
                        end
                    hit = bounce(0, longint'(ww << 16));
                    hit = bounce(1, longint'(wh << 16)) | hit;
                    if (hit)
                        for (int i = 0; i < 3; i++)
                            vel[i] = mul_q16(vel[i], BOUNCE_GAIN);
                    for (int i = 0; i < 3; i++)
                    begin
                        frc[i] = 0;
                        s.op[i] = int'(pos[i]);
                        s.op[3 + i] = int'(vel[i]);
                    end
                    s.hit = hit;
                    tick_states.push_back(s);
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, longint exp_v, longint got_v);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
        endfunction

        // Compare an emitted state with the oldest expected one
        function void check_state(logic [191:0] data, logic hit);
            state_t s;
            if (tick_states.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: state emitted with none expected");
                return;
            end
            s = tick_states.pop_front();
            for (int i = 0; i < 6; i++)
                if (int'(data[32*i +: 32]) != s.op[i])
                    flag($sformatf("field %0d", i), s.op[i], int'(data[32*i +: 32]));
            if (hit != s.hit)
                flag("hit_wall", s.hit, hit);
        endfunction

        function int pending();
            return tick_states.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid, s_tready;
    logic [255:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid, cfg_ready;
    logic [7:0]   cfg_index;
    logic [16:0]  cfg_data;

    state_tracker tracker;
    item_t        cur;
    bit           calm;
    int           cycles;

    particle_force_integrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Watch the three channels
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.note_item(cur);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_state(m_tdata, m_tuser[0]);
        if (rst_n && cfg_valid && cfg_ready)
            tracker.set_reg(cfg_index, cfg_data);
    end

    // Result back-pressure
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 31);

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("particle_force_integrator test failed");
            $finish;
        end
    end

    function automatic int pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3, 4, 5: return $urandom;
            default: return int'($urandom_range(0, 1100 << 16)) - (50 << 16);
        endcase
    endfunction

    function automatic int pick_small(int span);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic item_t rand_item();
        item_t   it;
        int unsigned k;
        k = $urandom_range(0, 99);
        it.kind = k < 10 ? KIND_LOAD : k < 28 ? KIND_CONST : k < 46 ? KIND_REPEL :
                  k < 62 ? KIND_ATTRACT : k < 96 ? KIND_TICK : 3'($urandom_range(5, 7));
        it.px = pick_word();
        it.py = pick_word();
        it.pz = pick_small(300 << 16);
        it.vx = pick_small(20 << 16);
        it.vy = pick_small(20 << 16);
        it.vz = pick_small(20 << 16);
        if (it.kind == KIND_CONST)
        begin
            it.px = pick_small(3 << 16);
            it.py = pick_small(3 << 16);
        end
        case ($urandom_range(0, 5))
            0: it.reach = 0;
            1: it.reach = 31'($urandom);
            2: it.reach = 31'h7FFF_FFFF;
            default: it.reach = 31'($urandom_range(1, 800 << 16));
        endcase
        it.strength = $urandom_range(0, 3) == 0 ? int'($urandom) : pick_small(8 << 16);
        return it;
    endfunction

    function automatic item_t make(logic [2:0] k, int x, int y, int z,
                                   int a, int b, int c, logic [30:0] r, int st);
        item_t it;
        it.kind = k; it.px = x; it.py = y; it.pz = z;
        it.vx = a; it.vy = b; it.vz = c; it.reach = r; it.strength = st;
        return it;
    endfunction

    task automatic send(item_t it);
        if (!calm && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cur <= it;
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {1'b0, it.strength, it.reach, it.vz, it.vy, it.vx, it.pz, it.py, it.px};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() > 0);
    endtask

    task automatic random_items(int n, int pause_at);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                hold_until_drained();
            send(rand_item());
        end
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        tracker = new();
        cycles = 0;
        calm = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        cur = make(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register defaults
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send(make(KIND_CONST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        send(make(KIND_CONST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(KIND_LOAD, 100 << 16, 100 << 16, 0, 1 << 16, -(1 << 16), 0, 0, 0));
        // zero offset
        send(make(KIND_REPEL, 100 << 16, 100 << 16, 0, 0, 0, 0, 0, 5 << 16));
        // outside reach
        send(make(KIND_REPEL, 300 << 16, 100 << 16, 0, 0, 0, 0, 10 << 16, 5 << 16));
        // unlimited reach
        send(make(KIND_REPEL, 90 << 16, 97 << 16, 4 << 16, 0, 0, 0, 0, 3 << 16));
        send(make(KIND_ATTRACT, 110 << 16, 90 << 16, 0, 0, 0, 0, 50 << 16, 2 << 16));
        send(make(KIND_ATTRACT, 50 << 16, 120 << 16, 0, 0, 0, 0, 31'h7FFF_FFFF,
                  32'h8000_0000));
        send(make(KIND_REPEL, 100 << 16, 99 << 16, 0, 0, 0, 0, 1 << 16, 32'h7FFF_FFFF));
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(3'd5, 1, 2, 3, 4, 5, 6, 7, 8));
        send(make(3'd6, -1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF, -1));
        send(make(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
        // offsets beyond 2^31
        send(make(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
        send(make(KIND_REPEL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0,
                  32'h7FFF_FFFF));
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(KIND_LOAD, 2000 << 16, -(3 << 16), 0, 5 << 16, -(7 << 16), 1, 0, 0));
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        random_items(200, -1);

        // No damping, walls at 4096, with a full drain part way
        write_reg(REG_DAMP, 17'd0);
        write_reg(REG_WALL_W, 17'd4096);
        write_reg(REG_WALL_H, 17'd4096);
        random_items(200, 100);

        // Full damping, pinned, walls at 1
        write_reg(REG_DAMP, Q_ONE);
        write_reg(REG_PINNED, 17'd1);
        write_reg(REG_WALL_W, 17'd1);
        write_reg(REG_WALL_H, 17'd1);
        // reversal of the most negative velocity saturates
        send(make(KIND_LOAD, -5, 0, 0, 32'h8000_0000, 0, 32'h8000_0000, 0, 0));
        send(make(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        random_items(150, -1);

        // Walls at zero and at the register top, no idling, junk register index
        calm = 1;
        write_reg(REG_DAMP, 17'($urandom_range(0, 65536)));
        write_reg(REG_PINNED, 17'd0);
        write_reg(REG_WALL_W, 17'd0);
        write_reg(REG_WALL_H, 17'h1FFF);
        write_reg(8'd9, 17'h1FFFF);
        write_reg(8'hFF, 17'h0);
        random_items(200, -1);
        calm = 0;

        write_reg(REG_DAMP, 17'($urandom_range(0, 65536)));
        write_reg(REG_WALL_W, 17'($urandom_range(1, 4096)));
        write_reg(REG_WALL_H, 17'($urandom_range(1, 4096)));
        random_items(280, -1);

        if (tracker.errors == 0)
            $display("particle_force_integrator test passed");
        else
            $display("particle_force_integrator test failed");
        $finish;
    end
endmodule

// File: files.f
sv/pfi_pkg.sv
sv/pfi_mul.sv
sv/pfi_sqrt.sv
sv/pfi_div.sv
sv/particle_force_integrator.sv
sv/pfi_check.sv
tb/sv/testbench.sv
